[hw/rtl/point_rigid_body_transform_core_defines.svh]
// Assertion macros for the point rigid body transform checker.
`ifndef POINT_RIGID_BODY_TRANSFORM_CORE_DEFINES_SVH
`define POINT_RIGID_BODY_TRANSFORM_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define PRBT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("prbt check failed");

// antecedent implies consequent in the same cycle
`define PRBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prbt check failed");

`endif

[hw/rtl/prbt_pkg.sv]
// Types, constants and helpers for the point rigid body transform.
`default_nettype none
package prbt_pkg;

    localparam int W_COORD = 32;
    localparam int W_ANGLE = 16;
    localparam int W_D     = 35;   // rotated coordinates, Q.16
    localparam int W_CS    = 33;   // cordic x/y, sin/cos Q2.30
    localparam int W_RES   = 33;   // residual angle, 2^32 per turn
    localparam int W_BASE  = 34;   // datum + shift
    localparam int W_PP    = W_D + 17;
    localparam int W_T     = 72;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [W_CS-1:0]  CORDIC_GAIN  = 33'sh0_26DD_3B6A;
    localparam logic signed [W_RES-1:0] QUARTER_TURN = 33'sh0_4000_0000;
    localparam logic signed [W_RES-1:0] HALF_TURN    = 33'sh0_8000_0000;

    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [W_CS-1:0]  x;
        logic signed [W_CS-1:0]  y;
        logic signed [W_RES-1:0] a;
        logic                    flip;
    } t_cord;

    typedef struct packed {
        logic signed [W_D-1:0]    dx;
        logic signed [W_D-1:0]    dy;
        logic signed [W_D-1:0]    dz;
        logic signed [W_BASE-1:0] bx;
        logic signed [W_BASE-1:0] by;
        logic signed [W_BASE-1:0] bz;
    } t_pay;

    typedef struct packed {
        logic signed [W_BASE-1:0] bx;
        logic signed [W_BASE-1:0] by;
        logic signed [W_BASE-1:0] bz;
        logic signed [W_D-1:0]    w;
        logic signed [W_CS-1:0]   c1;
        logic signed [W_CS-1:0]   s1;
        logic signed [W_CS-1:0]   c2;
        logic signed [W_CS-1:0]   s2;
    } t_carry;

    // widen angle to 2^32 per turn and fold into +-quarter turn
    function automatic t_cord f_seed(input logic [W_ANGLE-1:0] ang);
        t_cord r;
        logic signed [W_RES-1:0] a;
        a = W_RES'($signed(ang)) <<< 16;
        r.x = CORDIC_GAIN;
        r.y = '0;
        r.flip = 1'b0;
        if (a > QUARTER_TURN) begin
            a = a - HALF_TURN;
            r.flip = 1'b1;
        end else if (a < -QUARTER_TURN) begin
            a = a + HALF_TURN;
            r.flip = 1'b1;
        end
        r.a = a;
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/prbt_cordic_cell.sv]
// One CORDIC rotation-mode cell: a single micro-rotation, registered.
`default_nettype none
module prbt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic           i_clk,
    input  wire prbt_pkg::t_cord i_cord,
    output prbt_pkg::t_cord      o_cord
);
    import prbt_pkg::*;

    localparam logic signed [W_RES-1:0] ATAN_I = W_RES'($signed({1'b0, ATAN_TAB[STAGE]}));

    t_cord r_cord;
    t_cord n_cord;

    always_comb begin
        n_cord.flip = i_cord.flip;
        if (i_cord.a >= 0) begin
            n_cord.x = i_cord.x - (i_cord.y >>> STAGE);
            n_cord.y = i_cord.y + (i_cord.x >>> STAGE);
            n_cord.a = i_cord.a - ATAN_I;
        end else begin
            n_cord.x = i_cord.x + (i_cord.y >>> STAGE);
            n_cord.y = i_cord.y - (i_cord.x >>> STAGE);
            n_cord.a = i_cord.a + ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cord <= n_cord;
    end

    assign o_cord = r_cord;
endmodule
`default_nettype wire

[hw/rtl/prbt_rot.sv]
// Plane rotation with Q30 sin/cos, split products, round half up; two stages.
`default_nettype none
module prbt_rot (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic signed [prbt_pkg::W_D-1:0]    i_u,
    input  wire logic signed [prbt_pkg::W_D-1:0]    i_v,
    input  wire logic signed [prbt_pkg::W_CS-1:0]   i_c,
    input  wire logic signed [prbt_pkg::W_CS-1:0]   i_s,
    input  wire prbt_pkg::t_carry                   i_carry,
    output logic                                    o_valid,
    output logic signed [prbt_pkg::W_D-1:0]         o_u,
    output logic signed [prbt_pkg::W_D-1:0]         o_v,
    output prbt_pkg::t_carry                        o_carry
);
    import prbt_pkg::*;

    localparam logic signed [W_T-1:0] RND = W_T'(64'sd536870912);

    logic signed [16:0] ch, cl, sh, sl;
    logic signed [W_PP-1:0] r_uch, r_ucl, r_vsh, r_vsl, r_ush, r_usl, r_vch, r_vcl;
    t_carry r_carry1, r_carry2;
    logic r_v1, r_v2;
    logic signed [W_T-1:0] t1, t2;
    logic signed [W_D-1:0] r_u, r_v;

    assign ch = i_c[W_CS-1:16];
    assign cl = $signed({1'b0, i_c[15:0]});
    assign sh = i_s[W_CS-1:16];
    assign sl = $signed({1'b0, i_s[15:0]});

    always_ff @(posedge i_clk) begin
        r_uch <= W_PP'(i_u) * W_PP'(ch);
        r_ucl <= W_PP'(i_u) * W_PP'(cl);
        r_vsh <= W_PP'(i_v) * W_PP'(sh);
        r_vsl <= W_PP'(i_v) * W_PP'(sl);
        r_ush <= W_PP'(i_u) * W_PP'(sh);
        r_usl <= W_PP'(i_u) * W_PP'(sl);
        r_vch <= W_PP'(i_v) * W_PP'(ch);
        r_vcl <= W_PP'(i_v) * W_PP'(cl);
        r_carry1 <= i_carry;
    end

    assign t1 = (W_T'(r_uch) <<< 16) + W_T'(r_ucl) - (W_T'(r_vsh) <<< 16) - W_T'(r_vsl) + RND;
    assign t2 = (W_T'(r_ush) <<< 16) + W_T'(r_usl) + (W_T'(r_vch) <<< 16) + W_T'(r_vcl) + RND;

    always_ff @(posedge i_clk) begin
        r_u <= t1[W_D+29:30];
        r_v <= t2[W_D+29:30];
        r_carry2 <= r_carry1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_u = r_u;
    assign o_v = r_v;
    assign o_carry = r_carry2;
endmodule
`default_nettype wire

[hw/rtl/point_rigid_body_transform_core.sv]
// Top level: rigid-body move of one point about a pivot, fully pipelined.
//
// Usage:
//   Request channel: drive all input fields and pulse start. busy is always
//   low, so a request is taken at every edge where start is high; one
//   request per cycle is sustained.
//   Result channel: o_valid is high for one cycle with moved_x/y/z and
//   o_overflow. The receiver cannot stall; results arrive in request order.
//   Pipeline: input register, the CORDIC cell chain, sign fix-up, three
//   plane rotations (roll, pitch, yaw), output saturation. The CORDIC cell
//   chain sets the latency; throughput is one request per cycle.
//   Reset (synchronous, active low) empties the pipeline: all valid flags
//   clear, requests in flight are dropped. No configuration, no state
//   carried between requests.
//   Overflow: any coordinate clipped to the signed 32-bit range sets
//   o_overflow for that result.
`default_nettype none
module point_rigid_body_transform_core #(
    parameter int CORDIC_STAGES = prbt_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_point_x,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_point_y,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_point_z,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_datum_x,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_datum_y,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_datum_z,
    input  wire logic signed [prbt_pkg::W_ANGLE-1:0] i_roll_angle,
    input  wire logic signed [prbt_pkg::W_ANGLE-1:0] i_pitch_angle,
    input  wire logic signed [prbt_pkg::W_ANGLE-1:0] i_yaw_angle,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_shift_x,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_shift_y,
    input  wire logic signed [prbt_pkg::W_COORD-1:0] i_shift_z,
    output logic                                    o_valid,
    output logic signed [prbt_pkg::W_COORD-1:0]     o_moved_x,
    output logic signed [prbt_pkg::W_COORD-1:0]     o_moved_y,
    output logic signed [prbt_pkg::W_COORD-1:0]     o_moved_z,
    output logic                                    o_overflow
);
    import prbt_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam int W_SUM = W_D + 2;
    localparam logic signed [W_SUM-1:0] SAT_MAX = W_SUM'(64'sd2147483647);
    localparam logic signed [W_SUM-1:0] SAT_MIN = W_SUM'(-64'sd2147483648);

    t_cord cords [3][N+1];
    t_pay  r_pay [N+1];
    logic  r_vld [N+1];
    logic [W_ANGLE-1:0] pitch_neg;

    assign busy = 1'b0;
    assign pitch_neg = W_ANGLE'(0) - i_pitch_angle;

    // input register
    t_cord r_seed [3];
    always_ff @(posedge i_clk) begin
        r_seed[0] <= f_seed(i_roll_angle);
        r_seed[1] <= f_seed(pitch_neg);
        r_seed[2] <= f_seed(i_yaw_angle);
        r_pay[0].dx <= W_D'(i_point_x) - W_D'(i_datum_x);
        r_pay[0].dy <= W_D'(i_point_y) - W_D'(i_datum_y);
        r_pay[0].dz <= W_D'(i_point_z) - W_D'(i_datum_z);
        r_pay[0].bx <= W_BASE'(i_datum_x) + W_BASE'(i_shift_x);
        r_pay[0].by <= W_BASE'(i_datum_y) + W_BASE'(i_shift_y);
        r_pay[0].bz <= W_BASE'(i_datum_z) + W_BASE'(i_shift_z);
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cords[l][0] = r_seed[l];
        for (genvar k = 0; k < N; k++) begin : g_cell
            prbt_cordic_cell #(.STAGE(k)) u_cell (
                .i_clk  (i_clk),
                .i_cord (cords[l][k]),
                .o_cord (cords[l][k+1])
            );
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_pay
        always_ff @(posedge i_clk) begin
            r_pay[k+1] <= r_pay[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= start & ~busy;
        end
    end
    for (genvar k = 0; k < N; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // sign fix-up for folded angles
    logic signed [W_CS-1:0] r_c [3];
    logic signed [W_CS-1:0] r_s [3];
    t_pay r_pay_cs;
    logic r_vld_cs;
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_c[l] <= cords[l][N].flip ? -cords[l][N].x : cords[l][N].x;
            r_s[l] <= cords[l][N].flip ? -cords[l][N].y : cords[l][N].y;
        end
        r_pay_cs <= r_pay[N];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_cs <= 1'b0;
        end else begin
            r_vld_cs <= r_vld[N];
        end
    end

    // roll: (y,z); pitch: (x,z); yaw: (x,y)
    t_carry carry0, carry1, carry2, carry3;
    logic v1, v2, v3;
    logic signed [W_D-1:0] ry, rz, px, pz, yx, yy;

    always_comb begin
        carry0.bx = r_pay_cs.bx;
        carry0.by = r_pay_cs.by;
        carry0.bz = r_pay_cs.bz;
        carry0.w  = r_pay_cs.dx;
        carry0.c1 = r_c[1];
        carry0.s1 = r_s[1];
        carry0.c2 = r_c[2];
        carry0.s2 = r_s[2];
    end

    prbt_rot u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vld_cs),
        .i_u(r_pay_cs.dy), .i_v(r_pay_cs.dz), .i_c(r_c[0]), .i_s(r_s[0]),
        .i_carry(carry0),
        .o_valid(v1), .o_u(ry), .o_v(rz), .o_carry(carry1)
    );

    t_carry carry1p;
    always_comb begin
        carry1p = carry1;
        carry1p.w = ry;
    end

    prbt_rot u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v1),
        .i_u(carry1.w), .i_v(rz), .i_c(carry1.c1), .i_s(carry1.s1),
        .i_carry(carry1p),
        .o_valid(v2), .o_u(px), .o_v(pz), .o_carry(carry2)
    );

    t_carry carry2p;
    always_comb begin
        carry2p = carry2;
        carry2p.w = pz;
    end

    prbt_rot u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v2),
        .i_u(px), .i_v(carry2.w), .i_c(carry2.c2), .i_s(carry2.s2),
        .i_carry(carry2p),
        .o_valid(v3), .o_u(yx), .o_v(yy), .o_carry(carry3)
    );

    // add back pivot + shift, saturate
    logic signed [W_SUM-1:0] sx, sy, sz;
    logic ox, oy, oz;
    assign sx = W_SUM'(yx) + W_SUM'(carry3.bx);
    assign sy = W_SUM'(yy) + W_SUM'(carry3.by);
    assign sz = W_SUM'(carry3.w) + W_SUM'(carry3.bz);
    assign ox = (sx > SAT_MAX) || (sx < SAT_MIN);
    assign oy = (sy > SAT_MAX) || (sy < SAT_MIN);
    assign oz = (sz > SAT_MAX) || (sz < SAT_MIN);

    logic signed [W_COORD-1:0] r_mx, r_my, r_mz;
    logic r_ovf, r_out_vld;
    always_ff @(posedge i_clk) begin
        r_mx <= (sx > SAT_MAX) ? W_COORD'(SAT_MAX) : (sx < SAT_MIN) ? W_COORD'(SAT_MIN)
                                                                   : sx[W_COORD-1:0];
        r_my <= (sy > SAT_MAX) ? W_COORD'(SAT_MAX) : (sy < SAT_MIN) ? W_COORD'(SAT_MIN)
                                                                   : sy[W_COORD-1:0];
        r_mz <= (sz > SAT_MAX) ? W_COORD'(SAT_MAX) : (sz < SAT_MIN) ? W_COORD'(SAT_MIN)
                                                                   : sz[W_COORD-1:0];
        r_ovf <= ox | oy | oz;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= v3;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_moved_x  = r_mx;
    assign o_moved_y  = r_my;
    assign o_moved_z  = r_mz;
    assign o_overflow = r_ovf;
endmodule
`default_nettype wire

[hw/rtl/prbt_checker.sv]
// Port-level checker for the point rigid body transform, bound to the top.
`default_nettype none
`include "point_rigid_body_transform_core_defines.svh"
module prbt_checker #(
    parameter int LAT = prbt_pkg::CORDIC_STAGES_DEF + 9
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               o_valid,
    input wire logic signed [prbt_pkg::W_COORD-1:0] o_moved_x,
    input wire logic signed [prbt_pkg::W_COORD-1:0] o_moved_y,
    input wire logic signed [prbt_pkg::W_COORD-1:0] o_moved_z,
    input wire logic                               o_overflow
);
    import prbt_pkg::*;

    logic sat_x, sat_y, sat_z;
    assign sat_x = (o_moved_x == 32'sh7FFF_FFFF) || (o_moved_x == 32'sh8000_0000);
    assign sat_y = (o_moved_y == 32'sh7FFF_FFFF) || (o_moved_y == 32'sh8000_0000);
    assign sat_z = (o_moved_z == 32'sh7FFF_FFFF) || (o_moved_z == 32'sh8000_0000);

    `PRBT_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)
    `PRBT_ASSERT_IMPL(a_result_has_request, i_clk, i_rst_n, o_valid, $past(start, LAT))
    `PRBT_ASSERT_IMPL(a_ovf_means_clip, i_clk, i_rst_n, o_valid && o_overflow,
        sat_x || sat_y || sat_z)
endmodule

bind point_rigid_body_transform_core prbt_checker #(.LAT(CORDIC_STAGES + 9)) u_prbt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_moved_x  (o_moved_x),
    .o_moved_y  (o_moved_y),
    .o_moved_z  (o_moved_z),
    .o_overflow (o_overflow)
);
`default_nettype wire

[tb/tb_point_rigid_body_transform_core.sv]
// Testbench for point_rigid_body_transform_core: random and directed requests against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class prbt_scoreboard;
    typedef struct {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic               ovf;
    } t_moved;

    t_moved pending_moves[$];
    int     mismatches;

    function new();
        mismatches = 0;
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function void sincos(logic [15:0] ang, output longint c, output longint s);
        longint a, x, y, nx;
        bit     flip;
        a = longint'($signed(ang)) * 65536;
        x = 64'h26DD3B6A;
        y = 0;
        flip = 0;
        if (a > 64'sd1073741824) begin
            a -= 64'sd2147483648;
            flip = 1;
        end else if (a < -64'sd1073741824) begin
            a += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (a >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                a -= longint'(prbt_pkg::ATAN_TAB[i]);
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                a += longint'(prbt_pkg::ATAN_TAB[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    static function void turn_plane(inout longint u, inout longint v, input longint c,
                                    input longint s);
        longint t1, t2;
        t1 = u * c - v * s + (64'sd1 << 29);
        t2 = u * s + v * c + (64'sd1 << 29);
        u = t1 >>> 30;
        v = t2 >>> 30;
    endfunction

    static function logic signed [31:0] clip(longint v, inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function void note_request(logic signed [31:0] p[3], logic signed [31:0] d[3],
                               logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                               logic signed [31:0] sh[3]);
        longint x, y, z, c, s;
        t_moved m;
        logic   ovf;
        x = longint'(p[0]) - longint'(d[0]);
        y = longint'(p[1]) - longint'(d[1]);
        z = longint'(p[2]) - longint'(d[2]);
        sincos(roll, c, s);
        turn_plane(y, z, c, s);
        sincos(16'h0 - pitch, c, s);
        turn_plane(x, z, c, s);
        sincos(yaw, c, s);
        turn_plane(x, y, c, s);
        ovf = 0;
        m.mx = clip(x + longint'(d[0]) + longint'(sh[0]), ovf);
        m.my = clip(y + longint'(d[1]) + longint'(sh[1]), ovf);
        m.mz = clip(z + longint'(d[2]) + longint'(sh[2]), ovf);
        m.ovf = ovf;
        pending_moves.push_back(m);
    endfunction

    function void check_result(logic signed [31:0] mx, logic signed [31:0] my,
                               logic signed [31:0] mz, logic ovf);
        t_moved e;
        if (pending_moves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result x=%h y=%h z=%h ovf=%b", mx, my, mz, ovf);
            return;
        end
        e = pending_moves.pop_front();
        if (mx !== e.mx || my !== e.my || mz !== e.mz || ovf !== e.ovf) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                         e.mx, e.my, e.mz, e.ovf, mx, my, mz, ovf);
        end
    endfunction
endclass

module tb_point_rigid_body_transform_core;
    localparam int LATENCY = 16 + 9;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [31:0] pt[3], dt[3], sh[3];
    logic        [15:0] roll = 0, pitch = 0, yaw = 0;
    logic               o_valid, o_overflow;
    logic signed [31:0] o_moved_x, o_moved_y, o_moved_z;
    prbt_scoreboard     board;
    int                 cycles = 0;

    initial begin
        for (int k = 0; k < 3; k++) begin
            pt[k] = 0;
            dt[k] = 0;
            sh[k] = 0;
        end
    end

    always #5 i_clk = ~i_clk;

    point_rigid_body_transform_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(pt[0]), .i_point_y(pt[1]), .i_point_z(pt[2]),
        .i_datum_x(dt[0]), .i_datum_y(dt[1]), .i_datum_z(dt[2]),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .i_shift_x(sh[0]), .i_shift_y(sh[1]), .i_shift_z(sh[2]),
        .o_valid(o_valid), .o_moved_x(o_moved_x), .o_moved_y(o_moved_y),
        .o_moved_z(o_moved_z), .o_overflow(o_overflow)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid)
            board.check_result(o_moved_x, o_moved_y, o_moved_z, o_overflow);
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65536 * 200) - 65536 * 100;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(16'h4000 + $urandom_range(0, 2) - 1);
            3: return 16'(16'hC000 + $urandom_range(0, 2) - 1);
            4: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // hold start high across back-to-back requests
    task automatic send_request(int gap);
        logic signed [31:0] p[3], d[3], s[3];
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        for (int k = 0; k < 3; k++) begin
            p[k] = pt[k];
            d[k] = dt[k];
            s[k] = sh[k];
        end
        board.note_request(p, d, roll, pitch, yaw, s);
        @(negedge i_clk);
    endtask

    task automatic load(logic [31:0] v, logic [15:0] r, logic [15:0] pi, logic [15:0] y);
        for (int k = 0; k < 3; k++) begin
            pt[k] <= v;
            dt[k] <= ~v;
            sh[k] <= v;
        end
        roll <= r;
        pitch <= pi;
        yaw <= y;
    endtask

    initial begin
        int gap, wait_cycles;
        board = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        load(32'h7FFFFFFF, 16'h8000, 16'h8000, 16'h8000); send_request(0);
        load(32'h80000000, 16'h7FFF, 16'h0001, 16'hFFFF); send_request(0);
        load(32'h00010000, 16'h4000, 16'hC000, 16'h4001); send_request(1);
        load(32'h00000000, 16'h0000, 16'h0000, 16'h0000); send_request(0);
        load(32'hFFFF0000, 16'hBFFF, 16'h3FFF, 16'h2000); send_request(3);
        load(32'h12345678, 16'h8000, 16'h0000, 16'h0000); send_request(0);
        load(32'h40000000, 16'h0000, 16'h8000, 16'h0000); send_request(0);
        load(32'hC0000000, 16'h0000, 16'h0000, 16'h8000); send_request(2);
        for (int n = 0; n < 650; n++) begin
            for (int k = 0; k < 3; k++) begin
                pt[k] <= pick_coord();
                dt[k] <= pick_coord();
                sh[k] <= ($urandom_range(0, 2) == 0) ? pick_coord()
                                                     : $urandom_range(0, 1 << 20) - (1 << 19);
            end
            roll <= pick_angle();
            pitch <= pick_angle();
            yaw <= pick_angle();
            gap = (n % 100 < 30) ? 0 : $urandom_range(0, 9);
            send_request(gap);
        end
        start <= 0;
        wait_cycles = 0;
        while (board.pending_moves.size() != 0 && wait_cycles < 10 * LATENCY) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending_moves.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
